[rtl/affwd_pkg.sv]
// Shared types and constants for the frame-based audio ring FIFO.
package affwd_pkg;

    // Store geometry
    localparam int FRAME_COUNT = 32;
    localparam int SPF         = 1152;
    localparam int STORE_DEPTH = FRAME_COUNT * SPF;
    localparam int FRAME_W     = $clog2(FRAME_COUNT);
    localparam int OFF_W       = $clog2(SPF + 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths
    localparam int SAMPLE_W    = 16;
    localparam int PAIR_W      = 2 * SAMPLE_W;
    localparam int GAIN_W      = 10;
    localparam int AVAIL_W     = 11;
    localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 48;
    localparam int M_USER_W    = 2;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = GAIN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 1'b1;
    localparam logic [GAIN_W-1:0]    GAIN_RESET  = 10'd384;

    // Saturation bounds on the scaled product
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);

    // Item kind carried on the input tuser
    typedef enum logic {
        OP_PRODUCE = 1'b0,
        OP_CONSUME = 1'b1
    } t_op;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_COMMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

[rtl/affwd_ctrl.sv]
// Controller state machine: sequences load, prepare and commit of one item.
module affwd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  affwd_pkg::t_stat   i_stat,
    output logic               o_in_ready,
    output affwd_pkg::t_cmd    o_cmd
);

    affwd_pkg::t_state r_state;
    affwd_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= affwd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            affwd_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = affwd_pkg::ST_PREP;
            end
            affwd_pkg::ST_PREP: begin
                n_state = affwd_pkg::ST_COMMIT;
            end
            affwd_pkg::ST_COMMIT: begin
                if (i_stat.out_free) n_state = affwd_pkg::ST_IDLE;
            end
            default: begin
                n_state = affwd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            affwd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            affwd_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
            end
            affwd_pkg::ST_COMMIT: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[rtl/affwd_dp.sv]
// Datapath: sample store, gain scaling, frame pointers and the output register.
module affwd_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  affwd_pkg::t_cmd                     i_cmd,
    output affwd_pkg::t_stat                    o_stat,
    input  logic                                i_cfg_we,
    input  logic [affwd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [affwd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic [affwd_pkg::S_DATA_W-1:0]      i_in_data,
    input  logic                                i_in_user,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [affwd_pkg::M_DATA_W-1:0]      o_out_data,
    output logic [affwd_pkg::M_USER_W-1:0]      o_out_user
);

    localparam int FW  = affwd_pkg::FRAME_W;
    localparam int OW  = affwd_pkg::OFF_W;
    localparam int AW  = affwd_pkg::ADDR_W;
    localparam int SW  = affwd_pkg::SAMPLE_W;
    localparam int PW  = affwd_pkg::PROD_W;
    localparam int NF  = affwd_pkg::FRAME_COUNT;

    // Sample store, left in the low half
    logic [affwd_pkg::PAIR_W-1:0] mem [affwd_pkg::STORE_DEPTH];

    // Configuration
    logic [affwd_pkg::GAIN_W-1:0] r_gain;
    logic                         r_enabled;

    // Item held for the step
    affwd_pkg::t_op               r_op;
    logic signed [SW-1:0]         r_left_in;
    logic signed [SW-1:0]         r_right_in;
    logic signed [PW-1:0]         r_prod_l;
    logic signed [PW-1:0]         r_prod_r;
    logic [affwd_pkg::PAIR_W-1:0] r_rdata;

    // FIFO state
    logic [NF-1:0]                r_ready;
    logic [FW-1:0]                r_wf;
    logic [OW-1:0]                r_woff;
    logic [FW-1:0]                r_rf;
    logic [OW-1:0]                r_roff;
    logic [affwd_pkg::PAIR_W-1:0] r_last_pair;

    // Output register
    logic                         r_out_valid;
    logic [affwd_pkg::M_DATA_W-1:0] r_out_data;
    logic [affwd_pkg::M_USER_W-1:0] r_out_user;

    // Step results
    logic [NF-1:0]                n_ready;
    logic [FW-1:0]                n_wf;
    logic [OW-1:0]                n_woff;
    logic [FW-1:0]                n_rf;
    logic [OW-1:0]                n_roff;
    logic [affwd_pkg::PAIR_W-1:0] n_last_pair;
    logic [SW-1:0]                n_lo;
    logic [SW-1:0]                n_ro;
    logic                         n_rep;
    logic                         n_drop;
    logic [affwd_pkg::AVAIL_W-1:0] n_avail;
    logic [SW-1:0]                scaled_l;
    logic [SW-1:0]                scaled_r;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic [OW-1:0]                woff_inc;
    logic [OW-1:0]                roff_inc;

    function automatic logic [FW-1:0] nxt_frame(input logic [FW-1:0] f);
        return (f == FW'(NF - 1)) ? '0 : f + FW'(1);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [FW-1:0] f,
                                              input logic [OW-1:0] off);
        return AW'(f) * AW'(affwd_pkg::SPF) + AW'(off);
    endfunction

    // Divide by 256 toward zero, then clamp to 16 bits
    function automatic logic [SW-1:0] sat_scale(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] adj;
        logic signed [PW-1:0] q;
        adj = p[PW-1] ? (p + PW'(255)) : p;
        q   = adj >>> 8;
        if (q > affwd_pkg::SAT_HI) begin
            return {1'b0, {(SW-1){1'b1}}};
        end else if (q < affwd_pkg::SAT_LO) begin
            return {1'b1, {(SW-1){1'b0}}};
        end else begin
            return q[SW-1:0];
        end
    endfunction

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= affwd_pkg::GAIN_RESET;
            r_enabled <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                affwd_pkg::CFG_GAIN:    r_gain    <= i_cfg_wdata;
                affwd_pkg::CFG_ENABLED: r_enabled <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Capture item, then form the gain products
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= affwd_pkg::t_op'(i_in_user);
            r_left_in  <= i_in_data[SW-1:0];
            r_right_in <= i_in_data[2*SW-1:SW];
        end
        if (i_cmd.prep) begin
            r_prod_l <= PW'(r_left_in)  * PW'($signed({1'b0, r_gain}));
            r_prod_r <= PW'(r_right_in) * PW'($signed({1'b0, r_gain}));
        end
    end

    assign wr_addr  = addr_of(r_wf, r_woff);
    assign rd_addr  = addr_of(r_rf, r_roff);
    assign scaled_l = sat_scale(r_prod_l);
    assign scaled_r = sat_scale(r_prod_r);
    assign woff_inc = r_woff + OW'(1);
    assign roff_inc = r_roff + OW'(1);

    // Store access: read ahead in prepare, write on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_rdata <= mem[rd_addr];
        end
        if (i_cmd.commit && (r_op == affwd_pkg::OP_PRODUCE)) begin
            mem[wr_addr] <= {scaled_r, scaled_l};
        end
    end

    // Work out the step
    always_comb begin
        n_ready     = r_ready;
        n_wf        = r_wf;
        n_woff      = r_woff;
        n_rf        = r_rf;
        n_roff      = r_roff;
        n_last_pair = r_last_pair;
        n_lo        = '0;
        n_ro        = '0;
        n_rep       = 1'b0;
        n_drop      = 1'b0;
        if (r_op == affwd_pkg::OP_PRODUCE) begin
            // Drop the two oldest frames on overrun
            if ((r_woff == '0) && r_ready[r_wf]) begin
                n_ready[r_rf]            = 1'b0;
                n_ready[nxt_frame(r_rf)] = 1'b0;
                n_rf   = nxt_frame(nxt_frame(r_rf));
                n_roff = '0;
                n_drop = 1'b1;
            end
            if (woff_inc == OW'(affwd_pkg::SPF)) begin
                n_ready[r_wf] = 1'b1;
                n_wf   = nxt_frame(r_wf);
                n_woff = '0;
            end else begin
                n_woff = woff_inc;
            end
        end else if (r_enabled) begin
            // Pop, or repeat the last sample on underrun
            if (r_ready[r_rf]) begin
                n_last_pair = r_rdata;
                if (roff_inc == OW'(affwd_pkg::SPF)) begin
                    n_ready[r_rf] = 1'b0;
                    n_rf   = nxt_frame(r_rf);
                    n_roff = '0;
                end else begin
                    n_roff = roff_inc;
                end
            end else begin
                n_rep = 1'b1;
            end
            n_lo = n_last_pair[SW-1:0];
            n_ro = n_last_pair[2*SW-1:SW];
        end
        n_avail = n_ready[n_rf]
                ? (affwd_pkg::AVAIL_W'(affwd_pkg::SPF) - affwd_pkg::AVAIL_W'(n_roff))
                : '0;
    end

    // Advance FIFO state on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= '0;
            r_wf        <= '0;
            r_woff      <= '0;
            r_rf        <= '0;
            r_roff      <= '0;
            r_last_pair <= '0;
        end else if (i_cmd.commit) begin
            r_ready     <= n_ready;
            r_wf        <= n_wf;
            r_woff      <= n_woff;
            r_rf        <= n_rf;
            r_roff      <= n_roff;
            r_last_pair <= n_last_pair;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= affwd_pkg::M_DATA_W'({n_avail, n_ro, n_lo});
            r_out_user <= {n_drop, n_rep};
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_out_user      = r_out_user;

endmodule

[rtl/audio_frame_fifo_with_drop.sv]
// Top level of the frame-based stereo audio ring FIFO with overrun drop.
//
//  Channel   Direction  Handshake               Contents
//  s_axis    in         tvalid/tready           tuser: operation; tdata: left_in, right_in
//  m_axis    out        tvalid/tready           tuser: repeated, dropped;
//                                               tdata: left_out, right_out, available
//  cfg       in         i_cfg_we (no wait)      index 0 gain, index 1 enabled
//
//  Each item passes through capture, gain multiply with store read, then commit.
//  The single-port sample store read and the gain multiplier set these steps.
//  Commit waits while the output register still holds an untaken item.
//  Reset is synchronous, active low; the sample store is not cleared.
module audio_frame_fifo_with_drop (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [affwd_pkg::S_DATA_W-1:0]      s_axis_tdata,  // left_in, right_in
    input  logic                                s_axis_tuser,  // operation
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [affwd_pkg::M_DATA_W-1:0]      m_axis_tdata,  // left_out, right_out,
                                                               // available, zero pad
    output logic [affwd_pkg::M_USER_W-1:0]      m_axis_tuser,  // repeated, dropped
    input  logic                                i_cfg_we,
    input  logic [affwd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [affwd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    affwd_pkg::t_cmd  cmd;
    affwd_pkg::t_stat stat;

    affwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    affwd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

[rtl/affwd_chk.sv]
// Port-level checker for the audio frame FIFO, bound to the top level.
module affwd_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [affwd_pkg::M_DATA_W-1:0]      m_axis_tdata,
    input  logic [affwd_pkg::M_USER_W-1:0]      m_axis_tuser
);

    logic       r_head_op;
    logic       r_tail_op;
    logic [1:0] r_count;
    logic       in_take;
    logic       out_take;

    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign out_take = m_axis_tvalid && m_axis_tready;

    // Track the kinds of items in flight, oldest first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_op <= affwd_pkg::OP_PRODUCE;
            r_tail_op <= affwd_pkg::OP_PRODUCE;
            r_count   <= '0;
        end else begin
            case ({in_take, out_take})
                2'b10: begin
                    if (r_count == 2'd0) begin
                        r_head_op <= s_axis_tuser;
                    end else begin
                        r_tail_op <= s_axis_tuser;
                    end
                    r_count <= r_count + 2'd1;
                end
                2'b01: begin
                    r_head_op <= r_tail_op;
                    r_count   <= r_count - 2'd1;
                end
                2'b11: begin
                    if (r_count == 2'd1) begin
                        r_head_op <= s_axis_tuser;
                    end else begin
                        r_head_op <= r_tail_op;
                        r_tail_op <= s_axis_tuser;
                    end
                end
                default: ;
            endcase
        end
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                           && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Not ready in the cycle after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while previous one in progress");

    // A repeat only happens with nothing readable
    a_rep_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[42:32] == '0)
        else $error("repeat reported with samples available");

    // A produce result carries silence and no repeat
    a_prod_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_head_op == affwd_pkg::OP_PRODUCE)
        |-> m_axis_tdata[31:0] == '0 && !m_axis_tuser[0])
        else $error("produce result carries sample data");

    // Only a produce can drop frames
    a_cons_nodrop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_head_op == affwd_pkg::OP_CONSUME) |-> !m_axis_tuser[1])
        else $error("consume reported a drop");

endmodule

bind audio_frame_fifo_with_drop affwd_chk u_affwd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[dv/audio_frame_fifo_with_drop_tb.sv]
// Self-checking testbench for the frame-based stereo audio ring FIFO with overrun drop.
`timescale 1ns / 1ps

module audio_frame_fifo_with_drop_tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 8;
    localparam int RAND_ITEMS   = 175;

    typedef struct packed {
        logic [affwd_pkg::SAMPLE_W-1:0] left;
        logic [affwd_pkg::SAMPLE_W-1:0] right;
        logic                           repeated;
        logic                           dropped;
        logic [affwd_pkg::AVAIL_W-1:0]  avail;
    } t_audio_out;

    // Block ports
    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 s_axis_tvalid;
    logic                                 s_axis_tready;
    logic [affwd_pkg::S_DATA_W-1:0]       s_axis_tdata;   // left_in, right_in
    logic                                 s_axis_tuser;   // operation
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [affwd_pkg::M_DATA_W-1:0]       m_axis_tdata;   // left_out, right_out, available, pad
    logic [affwd_pkg::M_USER_W-1:0]       m_axis_tuser;   // repeated, dropped
    logic                                 i_cfg_we;
    logic [affwd_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [affwd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata;

    // Predicted FIFO state
    logic [affwd_pkg::PAIR_W-1:0] pair_store [affwd_pkg::STORE_DEPTH];
    bit                           frame_full [affwd_pkg::FRAME_COUNT];
    int                           wr_frame  = 0;
    int                           wr_off    = 0;
    int                           rd_frame  = 0;
    int                           rd_off    = 0;
    logic [affwd_pkg::PAIR_W-1:0] held_pair = '0;
    int                           gain_q    = affwd_pkg::GAIN_RESET;
    bit                           enabled_q = 1'b0;

    // Outputs still owed by the block, oldest first
    t_audio_out             audio_out_q[$];
    t_audio_out             last_sent;

    int                     idle_pct   = 0;
    int                     stall_pct  = 0;
    int                     mismatches = 0;
    int                     cycle_count = 0;

    audio_frame_fifo_with_drop uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Clock
    always #5 i_clk = ~i_clk;

    // Cycle counter with hard stop
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Scale by gain/256, truncate toward zero, saturate to 16 bits
    function automatic logic [affwd_pkg::SAMPLE_W-1:0] apply_gain(
        input logic signed [affwd_pkg::SAMPLE_W-1:0] s);
        int p;
        p = (int'(s) * gain_q) / 256;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[affwd_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic int samples_left();
        return frame_full[rd_frame] ? affwd_pkg::SPF - rd_off : 0;
    endfunction

    // Advance the predicted FIFO by one item and return the output it owes
    function automatic t_audio_out fifo_advance(input affwd_pkg::t_op op,
                                                input logic [affwd_pkg::SAMPLE_W-1:0] l,
                                                input logic [affwd_pkg::SAMPLE_W-1:0] r);
        t_audio_out res;
        res = '0;
        if (op == affwd_pkg::OP_PRODUCE) begin
            // Drop the two oldest frames when the frame to fill is still unread
            if (wr_off == 0 && frame_full[wr_frame]) begin
                repeat (2) begin
                    frame_full[rd_frame] = 1'b0;
                    rd_frame = (rd_frame + 1) % affwd_pkg::FRAME_COUNT;
                end
                rd_off = 0;
                res.dropped = 1'b1;
            end
            pair_store[wr_frame * affwd_pkg::SPF + wr_off] = {apply_gain(r), apply_gain(l)};
            wr_off++;
            if (wr_off >= affwd_pkg::SPF) begin
                frame_full[wr_frame] = 1'b1;
                wr_frame = (wr_frame + 1) % affwd_pkg::FRAME_COUNT;
                wr_off = 0;
            end
        end else if (enabled_q) begin
            // Pop one pair, or repeat the last one on underrun
            if (samples_left() != 0) begin
                held_pair = pair_store[rd_frame * affwd_pkg::SPF + rd_off];
                rd_off++;
                if (rd_off >= affwd_pkg::SPF) begin
                    frame_full[rd_frame] = 1'b0;
                    rd_frame = (rd_frame + 1) % affwd_pkg::FRAME_COUNT;
                    rd_off = 0;
                end
            end else begin
                res.repeated = 1'b1;
            end
            res.left  = held_pair[affwd_pkg::SAMPLE_W-1:0];
            res.right = held_pair[affwd_pkg::PAIR_W-1:affwd_pkg::SAMPLE_W];
        end
        res.avail = affwd_pkg::AVAIL_W'(samples_left());
        return res;
    endfunction

    // Offer one item after a random gap, hold it until taken, then predict
    task automatic send_item(input affwd_pkg::t_op op,
                             input logic [affwd_pkg::SAMPLE_W-1:0] l,
                             input logic [affwd_pkg::SAMPLE_W-1:0] r);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {r, l};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        last_sent = fifo_advance(op, l, r);
        audio_out_q.push_back(last_sent);
    endtask

    // Hold the sender off until every owed output has arrived, then settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (audio_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Write a register while the block is idle
    task automatic set_register(input logic [affwd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [affwd_pkg::CFG_DATA_W-1:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == affwd_pkg::CFG_GAIN) gain_q = val;
        else enabled_q = val[0];
        @(posedge i_clk);
    endtask

    function automatic logic [affwd_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return affwd_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    // Check one taken output against the oldest owed one
    task automatic check_result();
        t_audio_out want;
        if (audio_out_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] output with none owed: tdata %0h tuser %0h",
                         $realtime, m_axis_tdata, m_axis_tuser);
            return;
        end
        want = audio_out_q.pop_front();
        compare_field("left_out",  want.left,     m_axis_tdata[15:0]);
        compare_field("right_out", want.right,    m_axis_tdata[31:16]);
        compare_field("available", want.avail,    m_axis_tdata[42:32]);
        compare_field("repeated",  want.repeated, m_axis_tuser[0]);
        compare_field("dropped",   want.dropped,  m_axis_tuser[1]);
    endtask

    // Receiver: check taken outputs, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result();
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic set_traffic(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    // Silence while disabled, saturation, rounding and underrun from reset
    task automatic test_gain_and_silence();
        set_traffic(0, 0);
        send_item(affwd_pkg::OP_CONSUME, 16'h1234, 16'h5678);
        send_item(affwd_pkg::OP_PRODUCE, 16'h7FFF, 16'h8000);
        send_item(affwd_pkg::OP_PRODUCE, 16'h0000, 16'hFFFF);
        send_item(affwd_pkg::OP_PRODUCE, 16'h0001, 16'h1234);
        set_register(affwd_pkg::CFG_ENABLED, 10'd1);
        send_item(affwd_pkg::OP_CONSUME, 16'hFFFF, 16'hFFFF);
        set_register(affwd_pkg::CFG_GAIN, 10'd0);
        send_item(affwd_pkg::OP_PRODUCE, 16'h7FFF, 16'h8000);
        set_register(affwd_pkg::CFG_GAIN, 10'd1023);
        send_item(affwd_pkg::OP_PRODUCE, 16'h0100, 16'hFF00);
        send_item(affwd_pkg::OP_PRODUCE, 16'h7FFF, 16'h8000);
        set_register(affwd_pkg::CFG_GAIN, 10'd256);
        send_item(affwd_pkg::OP_PRODUCE, 16'h7FFF, 16'h8000);
        set_register(affwd_pkg::CFG_GAIN, 10'd1);
        send_item(affwd_pkg::OP_PRODUCE, 16'h00FF, 16'hFF01);
        send_item(affwd_pkg::OP_CONSUME, 16'h0000, 16'h0000);
        set_register(affwd_pkg::CFG_GAIN, affwd_pkg::GAIN_RESET);
    endtask

    // Complete the first frame, read it out, then run dry into repeats
    task automatic test_frame_handover();
        int fill;
        fill = affwd_pkg::SPF - wr_off;
        set_traffic(14, 14);
        repeat (fill) send_item(affwd_pkg::OP_PRODUCE, pick_sample(), pick_sample());
        repeat (affwd_pkg::SPF + 3)
            send_item(affwd_pkg::OP_CONSUME, affwd_pkg::SAMPLE_W'($urandom),
                      affwd_pkg::SAMPLE_W'($urandom));
        drain();
    endtask

    // Fill every frame, overrun, and overrun again with a part-read frame
    task automatic test_overrun_drop();
        int guard;
        set_traffic(0, 0);
        repeat (affwd_pkg::FRAME_COUNT * affwd_pkg::SPF)
            send_item(affwd_pkg::OP_PRODUCE, affwd_pkg::SAMPLE_W'($urandom),
                      affwd_pkg::SAMPLE_W'($urandom));
        send_item(affwd_pkg::OP_PRODUCE, pick_sample(), pick_sample());
        repeat (5) send_item(affwd_pkg::OP_CONSUME, 16'h0000, 16'h0000);
        guard = 0;
        do begin
            send_item(affwd_pkg::OP_PRODUCE, affwd_pkg::SAMPLE_W'($urandom),
                      affwd_pkg::SAMPLE_W'($urandom));
            guard++;
        end while (!last_sent.dropped && guard < 3 * affwd_pkg::SPF);
        // Disabled consumes leave the read side untouched
        set_register(affwd_pkg::CFG_ENABLED, 10'd0);
        repeat (2) send_item(affwd_pkg::OP_CONSUME, 16'hFFFF, 16'h0000);
        set_register(affwd_pkg::CFG_ENABLED, 10'd1);
        repeat (3) send_item(affwd_pkg::OP_CONSUME, 16'h0000, 16'hFFFF);
        drain();
    endtask

    task automatic random_phase(input int idle, input int stall);
        affwd_pkg::t_op op;
        set_traffic(idle, stall);
        repeat (RAND_ITEMS) begin
            op = ($urandom_range(99) < 50) ? affwd_pkg::OP_PRODUCE : affwd_pkg::OP_CONSUME;
            send_item(op, pick_sample(), pick_sample());
        end
        drain();
    endtask

    // Mixed traffic under several settings and idling patterns
    task automatic test_random_traffic();
        set_register(affwd_pkg::CFG_GAIN, 10'd1023);
        random_phase(0, 0);
        set_register(affwd_pkg::CFG_GAIN, 10'd0);
        random_phase(78, 0);
        set_register(affwd_pkg::CFG_GAIN, affwd_pkg::CFG_DATA_W'($urandom));
        set_register(affwd_pkg::CFG_ENABLED, 10'd0);
        random_phase(0, 78);
        set_register(affwd_pkg::CFG_GAIN, affwd_pkg::CFG_DATA_W'($urandom));
        set_register(affwd_pkg::CFG_ENABLED, 10'd1);
        random_phase(14, 14);
    endtask

    // Stimulus
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= affwd_pkg::OP_PRODUCE;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= affwd_pkg::CFG_GAIN;
        i_cfg_wdata   <= '0;
        foreach (frame_full[f]) frame_full[f] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_gain_and_silence();
        test_frame_handover();
        test_overrun_drop();
        test_random_traffic();

        drain();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
